// ===== hw/rtl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg
// Shared constants and types of the count-min sketch counter table.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

  localparam int OPCODE_W = 1;
  localparam int RANGE_W  = 6;
  localparam int DIGEST_W = 64;
  localparam int COUNT_W  = 63;
  localparam int WORD_W   = 16;

  localparam logic [COUNT_W-1:0] COUNTER_MAX = {COUNT_W{1'b1}};

  localparam int DEF_NUM_RANGES = 64;
  localparam int DEF_ROWS       = 8;
  localparam int DEF_ROW_WIDTH  = 1024;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cms_req_if.sv =====
// ----------------------------------------------------------------------------
// cms_req_if
// Request channel: opcode, range index and 128-bit digest.
// ----------------------------------------------------------------------------
`default_nettype none

interface cms_req_if;
  import cms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [RANGE_W-1:0]    range_index;
  logic [DIGEST_W-1:0]   digest_low;
  logic [DIGEST_W-1:0]   digest_high;

  modport source (output valid, opcode, range_index, digest_low, digest_high,
                  input ready);
  modport sink   (input valid, opcode, range_index, digest_low, digest_high,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cms_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cms_rsp_if
// Response channel: count estimate and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cms_rsp_if;
  import cms_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count_estimate;
  logic               overflow_error;

  modport source (output valid, count_estimate, overflow_error, input ready);
  modport sink   (input valid, count_estimate, overflow_error, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cms_front.sv =====
// ----------------------------------------------------------------------------
// cms_front
// Accepts request words, checks the range and works out one counter address
// per row (digest word modulo the row width) for the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_front #(
  parameter int NUM_RANGES = cms_pkg::DEF_NUM_RANGES,
  parameter int ROWS       = cms_pkg::DEF_ROWS,
  parameter int ROW_WIDTH  = cms_pkg::DEF_ROW_WIDTH,
  localparam int AW        = $clog2(NUM_RANGES * ROW_WIDTH),
  localparam int CMD_W     = ROWS * AW + 2
) (
  input  logic             clk,
  input  logic             rst,
  cms_req_if.sink          req,
  input  logic             clearing,
  output logic             push_valid,
  input  logic             push_ready,
  output logic [CMD_W-1:0] push_data
);
  import cms_pkg::*;

  localparam int  CW      = $clog2(ROW_WIDTH);
  localparam int  AXW     = RANGE_W + CW + 1;
  localparam bit  IS_POW2 = (ROW_WIDTH & (ROW_WIDTH - 1)) == 0;
  localparam logic [RANGE_W:0] NUM_RANGES_V = (RANGE_W + 1)'(NUM_RANGES);

  function automatic logic [AW-1:0] cell_addr(input logic [RANGE_W-1:0] rng,
                                               input logic [CW-1:0]      col);
    return AW'((AXW'(rng) * AXW'(ROW_WIDTH)) + AXW'(col));
  endfunction

  function automatic logic range_ok(input logic [RANGE_W-1:0] rng);
    return {1'b0, rng} < NUM_RANGES_V;
  endfunction

  logic [2*DIGEST_W-1:0] digest;
  assign digest = {req.digest_high, req.digest_low};

  if (IS_POW2) begin : g_mask
    // modulo is a mask: the word goes straight to the queue
    assign req.ready  = !clearing && push_ready;
    assign push_valid = req.valid && !clearing;

    always_comb begin
      for (int r = 0; r < ROWS; r++) begin
        push_data[r*AW +: AW] = cell_addr(req.range_index, digest[WORD_W*r +: CW]);
      end
      push_data[ROWS*AW]   = range_ok(req.range_index);
      push_data[ROWS*AW+1] = req.opcode;
    end
  end else begin : g_divide
    typedef enum logic [1:0] {F_IDLE, F_QUOT, F_REM, F_PUSH} fstate_t;

    // floor(2^32 / ROW_WIDTH): the quotient estimate is low by at most one
    localparam longint unsigned RECIP   = (64'd1 << 32) / ROW_WIDTH;
    localparam logic [31:0]     RECIP_V = 32'(RECIP);
    localparam logic [WORD_W:0] ROW_W   = (WORD_W + 1)'(ROW_WIDTH);

    fstate_t                state;
    logic [OPCODE_W-1:0]    op_q;
    logic [RANGE_W-1:0]     range_q;
    logic [WORD_W-1:0]      word_q    [ROWS];
    logic [WORD_W-1:0]      quot_q    [ROWS];
    logic [WORD_W:0]        rem_q     [ROWS];
    logic [WORD_W-1:0]      quot_next [ROWS];
    logic [WORD_W:0]        rem_next  [ROWS];
    logic [WORD_W:0]        rem_fix   [ROWS];

    assign req.ready  = (state == F_IDLE) && !clearing;
    assign push_valid = (state == F_PUSH);

    // reciprocal multiply, multiply back and subtract, one final correction
    always_comb begin
      logic [WORD_W+31:0]   est;
      logic [2*WORD_W+1:0]  prod_d;
      est    = '0;
      prod_d = '0;
      for (int r = 0; r < ROWS; r++) begin
        est          = (WORD_W + 32)'(word_q[r]) * (WORD_W + 32)'(RECIP_V);
        quot_next[r] = est[WORD_W+31 -: WORD_W];
        prod_d       = (2*WORD_W + 2)'(quot_q[r]) * (2*WORD_W + 2)'(ROW_W);
        rem_next[r]  = {1'b0, word_q[r]} - prod_d[WORD_W:0];
        rem_fix[r]   = (rem_q[r] >= ROW_W) ? rem_q[r] - ROW_W : rem_q[r];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        state <= F_IDLE;
      end else begin
        case (state)
          F_IDLE: begin
            if (req.valid && req.ready) begin
              op_q    <= req.opcode;
              range_q <= req.range_index;
              for (int r = 0; r < ROWS; r++) begin
                word_q[r] <= digest[WORD_W*r +: WORD_W];
              end
              state <= F_QUOT;
            end
          end
          F_QUOT: begin
            for (int r = 0; r < ROWS; r++) begin
              quot_q[r] <= quot_next[r];
            end
            state <= F_REM;
          end
          F_REM: begin
            for (int r = 0; r < ROWS; r++) begin
              rem_q[r] <= rem_next[r];
            end
            state <= F_PUSH;
          end
          F_PUSH: begin
            if (push_ready) begin
              state <= F_IDLE;
            end
          end
          default: state <= F_IDLE;
        endcase
      end
    end

    always_comb begin
      for (int r = 0; r < ROWS; r++) begin
        push_data[r*AW +: AW] = cell_addr(range_q, rem_fix[r][CW-1:0]);
      end
      push_data[ROWS*AW]   = range_ok(range_q);
      push_data[ROWS*AW+1] = op_q;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cms_fifo.sv =====
// ----------------------------------------------------------------------------
// cms_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = cms_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

  logic [W-1:0]  entry [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != FULL_CNT);
  assign pop_valid  = (fill != '0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        entry[wr_ptr] <= push_data;
        wr_ptr        <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cms_back.sv =====
// ----------------------------------------------------------------------------
// cms_back
// Carries out queued commands on one counter bank per row: clearing pass,
// read-modify-write for inserts, row-by-row minimum for queries.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_back #(
  parameter int NUM_RANGES = cms_pkg::DEF_NUM_RANGES,
  parameter int ROWS       = cms_pkg::DEF_ROWS,
  parameter int ROW_WIDTH  = cms_pkg::DEF_ROW_WIDTH,
  localparam int AW        = $clog2(NUM_RANGES * ROW_WIDTH),
  localparam int CMD_W     = ROWS * AW + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  logic [CMD_W-1:0] pop_data,
  cms_rsp_if.source        rsp,
  output logic             clearing
);
  import cms_pkg::*;

  localparam int BANK_DEPTH = NUM_RANGES * ROW_WIDTH;
  localparam int IW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BANK_DEPTH - 1);
  localparam logic [IW-1:0] LAST_ROW  = IW'(ROWS - 1);

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_READ, B_UPDATE, B_MIN, B_RESULT
  } bstate_t;

  bstate_t            state;
  opcode_t            cmd_op;
  logic               cmd_ok;
  logic [AW-1:0]      cmd_addr   [ROWS];
  logic [AW-1:0]      clear_addr;
  logic [IW-1:0]      row_idx;
  logic [COUNT_W-1:0] best;
  logic [COUNT_W-1:0] best_next;
  logic [COUNT_W-1:0] res_est;
  logic               res_err;
  logic               out_valid;
  logic [COUNT_W-1:0] out_est;
  logic               out_err;

  logic               mem_we;
  logic               mem_re;
  logic               load;
  logic [ROWS-1:0]    sat;
  logic [COUNT_W-1:0] rd_data    [ROWS];
  logic [COUNT_W-1:0] inc        [ROWS];
  logic [AW-1:0]      bank_waddr [ROWS];
  logic [COUNT_W-1:0] bank_wdata [ROWS];

  assign pop_ready = (state == B_IDLE);
  assign clearing  = (state == B_CLEAR);
  assign mem_we    = (state == B_CLEAR) || (state == B_UPDATE && cmd_op == OP_INSERT);
  assign mem_re    = (state == B_READ);
  assign load      = (state == B_RESULT) && (!out_valid || rsp.ready);

  assign rsp.valid          = out_valid;
  assign rsp.count_estimate = out_est;
  assign rsp.overflow_error = out_err;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      sat[r]        = (rd_data[r] == COUNTER_MAX);
      // a saturated counter keeps its value
      inc[r]        = sat[r] ? rd_data[r] : rd_data[r] + COUNT_W'(1);
      bank_waddr[r] = (state == B_CLEAR) ? clear_addr : cmd_addr[r];
      bank_wdata[r] = (state == B_CLEAR) ? '0 : inc[r];
    end
    best_next = (rd_data[row_idx] < best) ? rd_data[row_idx] : best;
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_bank
    logic [COUNT_W-1:0] mem [BANK_DEPTH];
    logic [COUNT_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (mem_we) begin
        mem[bank_waddr[r]] <= bank_wdata[r];
      end
      if (mem_re) begin
        rd_q <= mem[cmd_addr[r]];
      end
    end

    assign rd_data[r] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clear_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == LAST_ADDR) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop_valid) begin
            for (int r = 0; r < ROWS; r++) begin
              cmd_addr[r] <= pop_data[r*AW +: AW];
            end
            cmd_ok <= pop_data[ROWS*AW];
            cmd_op <= opcode_t'(pop_data[ROWS*AW+1]);
            if (pop_data[ROWS*AW]) begin
              state <= B_READ;
            end else begin
              // range beyond the table: zero word, no counter touched
              res_est <= '0;
              res_err <= 1'b0;
              state   <= B_RESULT;
            end
          end
        end
        B_READ: begin
          row_idx <= '0;
          best    <= COUNTER_MAX;
          state   <= (cmd_op == OP_INSERT) ? B_UPDATE : B_MIN;
        end
        B_UPDATE: begin
          res_est <= '0;
          res_err <= |sat;
          state   <= B_RESULT;
        end
        B_MIN: begin
          if (row_idx == LAST_ROW) begin
            res_est <= best_next;
            res_err <= 1'b0;
            state   <= B_RESULT;
          end else begin
            best    <= best_next;
            row_idx <= row_idx + IW'(1);
          end
        end
        B_RESULT: begin
          if (load) begin
            out_valid <= 1'b1;
            out_est   <= res_est;
            out_err   <= res_err;
            state     <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == B_CLEAR) || (cmd_ok && cmd_op == OP_INSERT))
    else $error("counter bank written outside clearing or insert");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> (state != B_IDLE))
    else $error("back still idle after taking a command");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == B_RESULT)
    else $error("response word raised outside result state");

  a_err_zero_est: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err) |-> (out_est == '0))
    else $error("overflow flagged with non-zero estimate");

endmodule

`default_nettype wire

// ===== hw/rtl/count_min_sketch_table_unit.sv =====
// ----------------------------------------------------------------------------
// count_min_sketch_table_unit
// Count-min sketch counter table: per-range rows of saturating counters,
// insert increments one counter per row, query returns the row minimum.
// ----------------------------------------------------------------------------
//
//   channel  dir  word contents                                   handshake
//   -------  ---  ----------------------------------------------  ----------
//   req      in   opcode, range_index, digest_low, digest_high    valid/ready
//   rsp      out  count_estimate, overflow_error                  valid/ready
//
// after reset a clearing pass zeroes every address of the banks;
// req.ready stays low while it runs
// back: one counter bank per row, read-modify-write for inserts through the
// registered bank read port, row-by-row minimum for queries
// front: combinational with a power-of-two row width, else registered steps
// (reciprocal multiply, then multiply back and subtract)
// a two-word command queue and the response register let front and back
// stall independently
// ----------------------------------------------------------------------------
`default_nettype none

module count_min_sketch_table_unit #(
  parameter int NUM_RANGES = cms_pkg::DEF_NUM_RANGES,
  parameter int ROWS       = cms_pkg::DEF_ROWS,
  parameter int ROW_WIDTH  = cms_pkg::DEF_ROW_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  cms_req_if.sink   req,
  cms_rsp_if.source rsp
);
  import cms_pkg::*;

  localparam int AW    = $clog2(NUM_RANGES * ROW_WIDTH);
  localparam int CMD_W = ROWS * AW + 2;

  logic             clearing;
  logic             push_valid;
  logic             push_ready;
  logic [CMD_W-1:0] push_data;
  logic             pop_valid;
  logic             pop_ready;
  logic [CMD_W-1:0] pop_data;

  cms_front #(
    .NUM_RANGES (NUM_RANGES),
    .ROWS       (ROWS),
    .ROW_WIDTH  (ROW_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  cms_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  cms_back #(
    .NUM_RANGES (NUM_RANGES),
    .ROWS       (ROWS),
    .ROW_WIDTH  (ROW_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .rsp       (rsp),
    .clearing  (clearing)
  );

endmodule

`default_nettype wire
